@@ hdl/wsfr_pkg.sv @@
`timescale 1ns / 1ps

package wsfr_pkg;

   // Parse phases.
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_TEXT       = 3'd0;
   localparam logic [2:0] KIND_PING       = 3'd1;
   localparam logic [2:0] KIND_MSG_END    = 3'd2;
   localparam logic [2:0] KIND_EMPTY_PING = 3'd3;
   localparam logic [2:0] KIND_CLOSED     = 3'd4;
   localparam logic [2:0] KIND_ERROR      = 3'd5;

   // Frame opcodes.
   localparam logic [3:0] OP_CONT       = 4'h0;
   localparam logic [3:0] OP_TEXT       = 4'h1;
   localparam logic [3:0] OP_BIN        = 4'h2;
   localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING       = 4'h9;
   localparam logic [3:0] OP_PONG       = 4'hA;

   // Length codes of the second header byte.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Header sizes in bytes.
   localparam logic [3:0] HDR_LEN_SHORT = 4'd2;
   localparam logic [3:0] HDR_LEN_16    = 4'd4;
   localparam logic [3:0] HDR_LEN_64    = 4'd10;

   // Control register indexes and reset values.
   localparam logic CSR_FRAME_LIMIT      = 1'b0;
   localparam logic CSR_MESSAGE_CAPACITY = 1'b1;
   localparam logic [31:0] FRAME_LIMIT_RESET      = 32'd4096;
   localparam logic [31:0] MESSAGE_CAPACITY_RESET = 32'd4096;

   typedef struct packed {
      logic [2:0]  parse_phase;
      logic [3:0]  ext_length_index;
      logic        final_flag;
      logic [3:0]  frame_opcode;
      logic [31:0] payload_length;
      logic [31:0] payload_count;
      logic [31:0] message_total;
      logic        halted;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic        last;
      logic [31:0] message_length;
   } result_type;

endpackage

@@ hdl/wsfr_step.sv @@
`timescale 1ns / 1ps

module wsfr_step
   import wsfr_pkg::*;
(
   input  parse_state_type state_cur,
   input  logic [7:0]      rx_byte,
   input  logic [31:0]     frame_limit,
   input  logic [31:0]     message_capacity,
   output parse_state_type state_in,
   output logic            emit,
   output result_type      result
);

   logic [6:0]  len7;
   logic [3:0]  idx_inc;
   logic [31:0] count_inc;
   logic        payload_end;
   logic        hdr_done;
   logic [3:0]  hdr_len;
   logic        too_big;
   logic        over_capacity;

   assign len7      = rx_byte[6:0];
   assign idx_inc   = state_cur.ext_length_index + 4'd1;
   assign count_inc = state_cur.payload_count + 32'd1;
   assign payload_end = (count_inc >= state_cur.payload_length);

   always_comb begin
      state_in = state_cur;
      emit     = 1'b0;
      result   = '0;
      hdr_done = 1'b0;
      hdr_len  = HDR_LEN_SHORT;
      too_big  = 1'b0;
      over_capacity = 1'b0;

      if (!state_cur.halted) begin
         unique case (state_cur.parse_phase)
            PH_HDR0: begin
               if (frame_limit < 32'd2) begin
                  emit = 1'b1;
                  result.kind = KIND_ERROR;
               end else begin
                  state_in.final_flag   = rx_byte[7];
                  state_in.frame_opcode = rx_byte[3:0];
                  state_in.parse_phase  = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (rx_byte[7]) begin
                  emit = 1'b1;
                  result.kind = KIND_ERROR;
               end else begin
                  state_in.ext_length_index = 4'd0;
                  state_in.payload_length   = 32'd0;
                  if (len7 == LEN_EXT16) begin
                     if (frame_limit < 32'd4) begin
                        emit = 1'b1;
                        result.kind = KIND_ERROR;
                     end else begin
                        state_in.parse_phase = PH_EXT16;
                     end
                  end else if (len7 == LEN_EXT64) begin
                     if (frame_limit < 32'd10) begin
                        emit = 1'b1;
                        result.kind = KIND_ERROR;
                     end else begin
                        state_in.parse_phase = PH_EXT64;
                     end
                  end else begin
                     state_in.payload_length = {25'd0, len7};
                     hdr_done = 1'b1;
                     hdr_len  = HDR_LEN_SHORT;
                  end
               end
            end
            PH_EXT16: begin
               state_in.payload_length   = {16'd0, state_cur.payload_length[7:0], rx_byte};
               state_in.ext_length_index = idx_inc;
               if (idx_inc >= 4'd2) begin
                  hdr_done = 1'b1;
                  hdr_len  = HDR_LEN_16;
               end
            end
            PH_EXT64: begin
               // The upper four length bytes must all be zero.
               if (state_cur.ext_length_index < 4'd4 && rx_byte != 8'd0) begin
                  emit = 1'b1;
                  result.kind = KIND_ERROR;
               end else begin
                  if (state_cur.ext_length_index >= 4'd4) begin
                     state_in.payload_length = {state_cur.payload_length[23:0], rx_byte};
                  end
                  state_in.ext_length_index = idx_inc;
                  if (idx_inc >= 4'd8) begin
                     hdr_done = 1'b1;
                     hdr_len  = HDR_LEN_64;
                  end
               end
            end
            PH_PAYLOAD: begin
               state_in.payload_count = count_inc;
               if (payload_end) begin
                  state_in.parse_phase = PH_HDR0;
               end
               case (state_cur.frame_opcode) inside
                  OP_CONT, OP_TEXT: begin
                     emit = 1'b1;
                     result.kind           = KIND_TEXT;
                     result.data_byte      = rx_byte;
                     result.message_length = state_cur.message_total + 32'd1;
                     if (payload_end && state_cur.final_flag) begin
                        result.last            = 1'b1;
                        state_in.message_total = 32'd0;
                     end else begin
                        state_in.message_total = state_cur.message_total + 32'd1;
                     end
                  end
                  OP_PING: begin
                     emit = 1'b1;
                     result.kind      = KIND_PING;
                     result.data_byte = rx_byte;
                     result.last      = payload_end;
                  end
                  OP_CONN_CLOSE: begin
                     if (payload_end) begin
                        emit = 1'b1;
                        result.kind = KIND_CLOSED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               state_in.parse_phase = PH_HDR0;
            end
         endcase

         // Checks made once the whole header is in.
         if (hdr_done) begin
            state_in.payload_count = 32'd0;
            too_big = ({29'd0, hdr_len} + {1'b0, state_in.payload_length})
                      > {1'b0, frame_limit};
            over_capacity = ({1'b0, state_cur.message_total}
                             + {1'b0, state_in.payload_length})
                            >= {1'b0, message_capacity};
            if (too_big) begin
               emit = 1'b1;
               result.kind = KIND_ERROR;
            end else begin
               state_in.parse_phase = PH_PAYLOAD;
               case (state_cur.frame_opcode) inside
                  OP_CONT, OP_TEXT: begin
                     if (over_capacity) begin
                        emit = 1'b1;
                        result.kind = KIND_ERROR;
                     end else if (state_in.payload_length == 32'd0) begin
                        state_in.parse_phase = PH_HDR0;
                        if (state_cur.final_flag) begin
                           emit = 1'b1;
                           result.kind            = KIND_MSG_END;
                           result.last            = 1'b1;
                           result.message_length  = state_cur.message_total;
                           state_in.message_total = 32'd0;
                        end
                     end
                  end
                  OP_PING: begin
                     if (state_in.payload_length == 32'd0) begin
                        state_in.parse_phase = PH_HDR0;
                        emit = 1'b1;
                        result.kind = KIND_EMPTY_PING;
                        result.last = 1'b1;
                     end
                  end
                  OP_CONN_CLOSE: begin
                     if (state_in.payload_length == 32'd0) begin
                        state_in.parse_phase = state_cur.parse_phase;
                        emit = 1'b1;
                        result.kind = KIND_CLOSED;
                     end
                  end
                  OP_BIN, OP_PONG: begin
                     if (state_in.payload_length == 32'd0) begin
                        state_in.parse_phase = PH_HDR0;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                     result.kind = KIND_ERROR;
                  end
               endcase
            end
         end

         // A close or an error stops the parser until reset.
         if (emit && (result.kind == KIND_CLOSED || result.kind == KIND_ERROR)) begin
            state_in.halted = 1'b1;
         end
      end
   end

endmodule

@@ hdl/websocket_frame_receiver_core.sv @@
`timescale 1ns / 1ps

// WebSocket frame receiver core, receive side of a client.
// The req channel carries one received stream byte per word; the rsp channel
// returns zero or one result word per byte: a text payload byte, a ping
// payload byte, an empty message end, an empty ping, closed, or error.
// Both channels use valid/stall; a word moves at a clock edge where valid is
// high and stall is low. The csr port writes frame_limit (index 0) and
// message_capacity (index 1); write it only while the core is idle.
// Each byte is parsed in the cycle it is accepted and its result lands in
// the rsp output register, so a result is visible in the cycle after its byte.
// Throughput is one byte per clock unless a held result stalls, set by the
// single output register: a byte is taken whenever it is empty or draining.
// When the downstream side stalls with a result held, req_stall rises and
// the core holds both its state and the held result word.
// A synchronous reset returns the parser to the first header byte, clears
// the message total and the halted flag, and loads both limits with 4096.
// After a close or an error is reported the core drops every further byte
// silently until the next reset.

module websocket_frame_receiver_core
   import wsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Received byte stream.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Parse results.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_message_length,
   // Control register writes.
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic [31:0]     frame_limit_ff;
   logic [31:0]     message_capacity_ff;
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   result_type      result;
   logic            emit;
   logic            req_accept;

   // The input side only waits when a result is held and the sink stalls.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   wsfr_step u_step (
      .state_cur        (state_ff),
      .rx_byte          (req_rx_byte),
      .frame_limit      (frame_limit_ff),
      .message_capacity (message_capacity_ff),
      .state_in         (state_in),
      .emit             (emit),
      .result           (result)
   );

   // Parser state advances only on an accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.parse_phase      <= PH_HDR0;
         state_ff.ext_length_index <= 4'd0;
         state_ff.final_flag       <= 1'b0;
         state_ff.frame_opcode     <= OP_CONT;
         state_ff.payload_length   <= 32'd0;
         state_ff.payload_count    <= 32'd0;
         state_ff.message_total    <= 32'd0;
         state_ff.halted           <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff      <= FRAME_LIMIT_RESET;
         message_capacity_ff <= MESSAGE_CAPACITY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_LIMIT:      frame_limit_ff      <= csr_data;
            CSR_MESSAGE_CAPACITY: message_capacity_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Output register: refilled by an accepted byte, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last           = rsp_ff.last;
   assign rsp_message_length = rsp_ff.message_length;

endmodule

@@ test/websocket_frame_receiver_core_test.sv @@
`timescale 1ns / 1ps

module websocket_frame_receiver_core_test;
   import wsfr_pkg::*;

   // The cycle limit leaves a wide margin over a clean run for the heaviest
   // idling and stalling.
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;
   logic [31:0] rsp_message_length;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = 32'h0;

   websocket_frame_receiver_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_message_length (rsp_message_length),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Bytes of the received stream that are still waiting to be sent, and the
   // result words that the parser model says must come back, oldest first.
   logic [7:0] rx_stream[$];
   result_type parse_results_due[$];
   result_type due_word;

   // Idling percentages for the current phase.
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Counters for the summary and the verdict.
   int fail_count = 0;
   int bytes_taken = 0;
   int words_seen = 0;
   int cycle_count = 0;
   string end_case = "no terminating frame";

   // Stream generator bookkeeping. It mirrors the limits it has written so
   // that the bulk of the stream stays legal and the parser never halts early.
   logic [31:0] gen_limit = FRAME_LIMIT_RESET;
   logic [31:0] gen_capacity = MESSAGE_CAPACITY_RESET;
   longint gen_total = 0;
   int fed_count = 0;

   // Parser model state. It is updated at the clock edge where a word or a
   // register write is observed, so it always matches what the core has taken.
   logic [31:0] lim_frame;
   logic [31:0] lim_capacity;
   logic [2:0]  ps_phase;
   logic [3:0]  ps_ext;
   logic        ps_fin;
   logic [3:0]  ps_op;
   logic [31:0] ps_plen;
   logic [31:0] ps_count;
   logic [31:0] ps_total;
   logic        ps_halted;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Queue a result word. A close or an error stops the parser for good, so
   // the model halts with it.
   task automatic post_result(input logic [2:0] k, input logic [7:0] d, input logic l,
                              input logic [31:0] n);
      result_type w;
      w.kind = k;
      w.data_byte = d;
      w.last = l;
      w.message_length = n;
      parse_results_due.push_back(w);
      if (k == KIND_CLOSED || k == KIND_ERROR)
         ps_halted = 1'b1;
   endtask

   // Checks made once the whole header is in: the frame size first, then the
   // message capacity for text and continuation frames, then the opcode.
   task automatic close_header(input logic [3:0] hdr);
      logic [32:0] frame_size;
      logic [32:0] msg_size;
      frame_size = {29'b0, hdr} + {1'b0, ps_plen};
      msg_size = {1'b0, ps_total} + {1'b0, ps_plen};
      ps_count = 32'd0;
      ps_phase = PH_PAYLOAD;
      if (frame_size > {1'b0, lim_frame}) begin
         post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
      end else begin
         case (ps_op)
            OP_CONT, OP_TEXT: begin
               if (msg_size >= {1'b0, lim_capacity}) begin
                  post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
               end else if (ps_plen == 32'd0) begin
                  // An empty final fragment ends the message; an empty
                  // middle fragment says nothing.
                  ps_phase = PH_HDR0;
                  if (ps_fin) begin
                     post_result(KIND_MSG_END, 8'h00, 1'b1, ps_total);
                     ps_total = 32'd0;
                  end
               end
            end
            OP_PING: begin
               if (ps_plen == 32'd0) begin
                  ps_phase = PH_HDR0;
                  post_result(KIND_EMPTY_PING, 8'h00, 1'b1, 32'd0);
               end
            end
            OP_CONN_CLOSE: begin
               if (ps_plen == 32'd0)
                  post_result(KIND_CLOSED, 8'h00, 1'b0, 32'd0);
            end
            OP_BIN, OP_PONG: begin
               if (ps_plen == 32'd0)
                  ps_phase = PH_HDR0;
            end
            default: begin
               post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
            end
         endcase
      end
   endtask

   // Advance the parser model by one received byte.
   task automatic parse_rx_byte(input logic [7:0] b);
      logic at_end;
      if (!ps_halted) begin
         case (ps_phase)
            PH_HDR0: begin
               if (lim_frame < 32'd2) begin
                  post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
               end else begin
                  ps_fin = b[7];
                  ps_op = b[3:0];
                  ps_phase = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (b[7]) begin
                  // Frames from a server must not be masked.
                  post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
               end else begin
                  ps_ext = 4'd0;
                  ps_plen = 32'd0;
                  if (b[6:0] == LEN_EXT16) begin
                     if (lim_frame < 32'd4)
                        post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
                     else
                        ps_phase = PH_EXT16;
                  end else if (b[6:0] == LEN_EXT64) begin
                     if (lim_frame < 32'd10)
                        post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
                     else
                        ps_phase = PH_EXT64;
                  end else begin
                     ps_plen = {25'b0, b[6:0]};
                     close_header(HDR_LEN_SHORT);
                  end
               end
            end
            PH_EXT16: begin
               ps_plen = {16'h0, ps_plen[7:0], b};
               ps_ext = ps_ext + 4'd1;
               if (ps_ext >= 4'd2)
                  close_header(HDR_LEN_16);
            end
            PH_EXT64: begin
               // The upper half of a 64-bit length must be zero.
               if (ps_ext < 4'd4 && b != 8'h00) begin
                  post_result(KIND_ERROR, 8'h00, 1'b0, 32'd0);
               end else begin
                  if (ps_ext >= 4'd4)
                     ps_plen = {ps_plen[23:0], b};
                  ps_ext = ps_ext + 4'd1;
                  if (ps_ext >= 4'd8)
                     close_header(HDR_LEN_64);
               end
            end
            PH_PAYLOAD: begin
               ps_count = ps_count + 32'd1;
               at_end = (ps_count >= ps_plen);
               if (at_end)
                  ps_phase = PH_HDR0;
               case (ps_op)
                  OP_CONT, OP_TEXT: begin
                     ps_total = ps_total + 32'd1;
                     if (at_end && ps_fin) begin
                        post_result(KIND_TEXT, b, 1'b1, ps_total);
                        ps_total = 32'd0;
                     end else begin
                        post_result(KIND_TEXT, b, 1'b0, ps_total);
                     end
                  end
                  OP_PING: post_result(KIND_PING, b, at_end, 32'd0);
                  OP_CONN_CLOSE: begin
                     if (at_end)
                        post_result(KIND_CLOSED, 8'h00, 1'b0, 32'd0);
                  end
                  default: ;
               endcase
            end
            default: ps_phase = PH_HDR0;
         endcase
      end
   endtask

   // Driver. A word stays on the port until the core takes it; a new one is
   // offered, or the port idles, only after that.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Downstream back-pressure.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Monitor. Every value is sampled as it stood before the edge. Result words
   // are checked first; the byte taken at the same edge can only produce a
   // word at a later edge.
   always @(posedge clock) begin
      if (reset) begin
         lim_frame = FRAME_LIMIT_RESET;
         lim_capacity = MESSAGE_CAPACITY_RESET;
         ps_phase = PH_HDR0;
         ps_ext = 4'd0;
         ps_fin = 1'b0;
         ps_op = 4'd0;
         ps_plen = 32'd0;
         ps_count = 32'd0;
         ps_total = 32'd0;
         ps_halted = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (parse_results_due.size() == 0) begin
               $error("result word with nothing due: kind %0d, data %0h", rsp_kind,
                      rsp_data_byte);
               fail_count++;
            end else begin
               due_word = parse_results_due.pop_front();
               if (rsp_kind !== due_word.kind) begin
                  $error("kind: expected %0d, got %0d", due_word.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_data_byte !== due_word.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", due_word.data_byte,
                         rsp_data_byte);
                  fail_count++;
               end
               if (rsp_last !== due_word.last) begin
                  $error("last: expected %0d, got %0d", due_word.last, rsp_last);
                  fail_count++;
               end
               if (rsp_message_length !== due_word.message_length) begin
                  $error("message_length: expected %0d, got %0d",
                         due_word.message_length, rsp_message_length);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            parse_rx_byte(req_rx_byte);
         end
         if (csr_write) begin
            if (csr_index == CSR_FRAME_LIMIT)
               lim_frame = csr_data;
            else
               lim_capacity = csr_data;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Queue one frame. The length is sent in the short, 16-bit or 64-bit form
   // picked by enc, even where a shorter form would do. A negative fill means
   // random payload bytes. The reserved header bits are random: nothing
   // checks them.
   task automatic push_frame(input logic fin_bit, input logic [3:0] op, input int enc,
                             input int plen, input int fill);
      logic [31:0] n;
      logic [31:0] rnd;
      int hdr;
      n = plen;
      rnd = $urandom;
      rx_stream.push_back({fin_bit, rnd[2:0], op});
      if (enc == 0) begin
         rx_stream.push_back({1'b0, n[6:0]});
         hdr = 2;
      end else if (enc == 1) begin
         rx_stream.push_back({1'b0, LEN_EXT16});
         rx_stream.push_back(n[15:8]);
         rx_stream.push_back(n[7:0]);
         hdr = 4;
      end else begin
         rx_stream.push_back({1'b0, LEN_EXT64});
         repeat (4) rx_stream.push_back(8'h00);
         rx_stream.push_back(n[31:24]);
         rx_stream.push_back(n[23:16]);
         rx_stream.push_back(n[15:8]);
         rx_stream.push_back(n[7:0]);
         hdr = 10;
      end
      for (int i = 0; i < plen; i++) begin
         rnd = $urandom;
         rx_stream.push_back(fill < 0 ? rnd[7:0] : fill[7:0]);
      end
      if (op == OP_TEXT || op == OP_CONT)
         gen_total = fin_bit ? 0 : gen_total + plen;
      fed_count += hdr + plen;
   endtask

   // A legal frame with random content. Its length stays within the frame
   // limit and, for message fragments, below the remaining message capacity.
   task automatic push_random_frame();
      int pick;
      int enc;
      int hdr;
      logic fin_bit;
      logic [3:0] op;
      longint room;
      longint cap_room;
      longint span;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         op = OP_TEXT;
      else if (pick < 60)
         op = OP_CONT;
      else if (pick < 80)
         op = OP_PING;
      else if (pick < 90)
         op = OP_PONG;
      else
         op = OP_BIN;
      fin_bit = ($urandom_range(0, 99) < 60);
      pick = $urandom_range(0, 99);
      enc = (pick < 70) ? 0 : (pick < 90) ? 1 : 2;
      hdr = (enc == 0) ? 2 : (enc == 1) ? 4 : 10;
      if (gen_limit < hdr) begin
         enc = 0;
         hdr = 2;
      end
      room = gen_limit;
      room = room - hdr;
      if (op == OP_TEXT || op == OP_CONT) begin
         cap_room = gen_capacity;
         cap_room = cap_room - 1 - gen_total;
         if (cap_room < room)
            room = cap_room;
      end
      // Mostly short payloads, a few long enough to need the 16-bit form.
      pick = $urandom_range(0, 99);
      span = (pick < 70) ? 8 : (pick < 95) ? 40 : 260;
      if (enc == 0 && span > 125)
         span = 125;
      if (room < span)
         span = room;
      push_frame(fin_bit, op, enc, $urandom_range(0, 32'(span)), -1);
   endtask

   // Random frames worth about goal stream bytes, then an empty final
   // fragment if a message is still open, so that the limits can change.
   task automatic push_random_frames(input int goal);
      int start;
      start = fed_count;
      while (fed_count - start < goal)
         push_random_frame();
      if (gen_total != 0)
         push_frame(1'b1, OP_CONT, 0, 0, -1);
   endtask

   // Wait until every byte is taken and every due word has come back, then
   // let the core finish a header byte that has no word.
   task automatic wait_drained();
      @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || parse_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_LIMIT)
         gen_limit = value;
      else
         gen_capacity = value;
      @(negedge clock);
   endtask

   // One limit setting with its own idling profile.
   task automatic run_setting(input logic [31:0] limit, input logic [31:0] capacity,
                              input int send_pct, input int recv_pct);
      write_reg(CSR_FRAME_LIMIT, limit);
      write_reg(CSR_MESSAGE_CAPACITY, capacity);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      push_random_frames(120);
      wait_drained();
   endtask

   // Stimulus. Since a close or an error halts the core until reset, and reset
   // comes only once, the whole run is legal traffic and a single terminating
   // frame, picked at random, comes at the very end.
   initial begin
      logic [3:0] op;
      logic [31:0] limit;
      int pos;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at the reset limits: a fragmented message whose
      // payload bytes are all zeros and all ones, an empty final message, an
      // empty middle fragment, an empty ping, a ping with a 64-bit length,
      // and a skipped pong.
      push_frame(1'b0, OP_TEXT, 0, 1, 8'h00);
      push_frame(1'b1, OP_CONT, 1, 1, 8'hFF);
      push_frame(1'b1, OP_TEXT, 0, 0, -1);
      push_frame(1'b0, OP_TEXT, 0, 0, -1);
      push_frame(1'b1, OP_PING, 0, 0, -1);
      push_frame(1'b1, OP_PING, 2, 1, 8'hA5);
      push_frame(1'b1, OP_PONG, 0, 1, 8'h5A);
      push_frame(1'b1, OP_CONT, 0, 0, -1);
      push_random_frames(120);
      wait_drained();

      run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 49, 0);
      // Smallest limits: only empty frames with short headers get through.
      run_setting(32'd2, 32'd1, 0, 49);
      run_setting($urandom_range(12, 200), $urandom_range(1, 300), 31, 31);
      run_setting($urandom_range(300, 70000), $urandom_range(100, 100000), 0, 0);

      // Terminating frame.
      write_reg(CSR_FRAME_LIMIT, 32'd4096);
      write_reg(CSR_MESSAGE_CAPACITY, 32'd4096);
      send_idle_pct = 31;
      stall_pct = 31;
      case ($urandom_range(0, 8))
         0: begin
            end_case = "a masked frame";
            rx_stream.push_back({1'b1, 3'b000, OP_TEXT});
            rx_stream.push_back({1'b1, 7'($urandom_range(0, 127))});
         end
         1: begin
            end_case = "a 64-bit length with a nonzero upper half";
            pos = $urandom_range(0, 3);
            rx_stream.push_back({1'b1, 3'b000, OP_BIN});
            rx_stream.push_back({1'b0, LEN_EXT64});
            for (int i = 0; i < 4; i++)
               rx_stream.push_back(i == pos ? 8'($urandom_range(1, 255)) : 8'h00);
         end
         2: begin
            end_case = "a 64-bit length one beyond the frame limit";
            limit = $urandom_range(10, 300);
            write_reg(CSR_FRAME_LIMIT, limit);
            push_frame(1'b1, OP_PING, 2, limit - 9, -1);
         end
         3: begin
            end_case = "a text frame that fills the message capacity";
            limit = $urandom_range(1, 125);
            write_reg(CSR_MESSAGE_CAPACITY, limit);
            push_frame(1'($urandom_range(0, 1)), OP_TEXT, 0, limit, -1);
         end
         4: begin
            end_case = "an unknown opcode";
            do
               op = 4'($urandom_range(3, 15));
            while (op == OP_CONN_CLOSE || op == OP_PING || op == OP_PONG);
            push_frame(1'b1, op, 0, $urandom_range(0, 20), -1);
         end
         5: begin
            end_case = "an extended length form the frame limit cannot hold";
            limit = $urandom_range(2, 9);
            write_reg(CSR_FRAME_LIMIT, limit);
            rx_stream.push_back({1'b1, 3'b000, OP_TEXT});
            rx_stream.push_back({1'b0, limit < 4 ? LEN_EXT16 : LEN_EXT64});
         end
         6: begin
            end_case = "an empty close frame";
            push_frame(1'b1, OP_CONN_CLOSE, 0, 0, -1);
         end
         7: begin
            end_case = "a close frame with payload";
            push_frame(1'b1, OP_CONN_CLOSE, $urandom_range(0, 1), $urandom_range(1, 20), -1);
         end
         default: begin
            end_case = "a short frame one beyond the frame limit";
            limit = $urandom_range(2, 100);
            write_reg(CSR_FRAME_LIMIT, limit);
            push_frame(1'b1, OP_TEXT, 0, limit - 1, -1);
         end
      endcase
      // The core is halted now and must stay silent, even for good frames.
      push_frame(1'b1, OP_PING, 0, 3, -1);
      repeat (8) rx_stream.push_back(8'($urandom_range(0, 255)));
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d stream bytes and checked %0d result words under five limit settings,",
               bytes_taken, words_seen);
      $display("both extremes included; the stream ended with %s.", end_case);
      if (fail_count == 0 && parse_results_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
